// ===== rtl/core/package_deframer_md5_check_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef PACKAGE_DEFRAMER_MD5_CHECK_DEFINES_SVH
`define PACKAGE_DEFRAMER_MD5_CHECK_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define PDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define PDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/pdm_pkg.sv =====
// Types, constants and MD5 tables for the package deframer.
package pdm_pkg;

  typedef enum logic [2:0] {PS_PACKAGE, PS_FILEHDR, PS_NAME, PS_DATA, PS_DONE} stage_t;
  typedef enum logic [1:0] {CT_READY, CT_FINAL, CT_CHECK} ctl_t;
  typedef enum logic [1:0] {MD_IDLE, MD_ROUND, MD_ADD} md_state_t;

  localparam logic [1:0] CLS_NAME  = 2'd0;
  localparam logic [1:0] CLS_DATA  = 2'd1;
  localparam logic [1:0] CLS_EMPTY = 2'd2;

  localparam logic [1:0] STS_BUSY     = 2'd0;
  localparam logic [1:0] STS_MATCH    = 2'd1;
  localparam logic [1:0] STS_MISMATCH = 2'd2;
  localparam logic [1:0] STS_BAD_HDR  = 2'd3;

  localparam logic [4:0]  PKG_HDR_BYTES    = 5'd8;
  localparam logic [4:0]  FILE_HDR_BYTES   = 5'd24;
  localparam logic [31:0] DEFAULT_HDR_SIZE = 32'd25;

  localparam logic [127:0] MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  typedef struct packed {
    logic       start;
    logic       byte_en;
    logic       final_en;
    logic [7:0] data;
  } md5_cmd_t;

  typedef struct packed {
    logic         busy;
    logic [127:0] digest;
  } md5_sts_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;  6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee;  6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;  6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;  6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821;  6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;  6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453;  6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;  6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed;  6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;  6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681;  6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;  6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70;  6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;  6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5;  6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;  6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039;  6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;  6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0;  6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;  6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [3:0] i);
    logic [4:0] s;
    case (i)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/package_deframer_md5_check.sv =====
// Top level of the package deframer with per-file MD5 check.
// Header, name and data bytes are taken whenever input is not stalled. Every 64th data
// byte of a file starts the shared MD5 round unit (one round per cycle) to compress the
// block before the next byte is taken. At the end of each file the unit pads and
// compresses the last block, plus one more when it is too full for the length, before
// the digest compare. Input is stalled while the round unit works or a result waits.
`include "package_deframer_md5_check_defines.svh"

module package_deframer_md5_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_begin_package,
  input  logic [7:0]  in_in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_byte_class,
  output logic [7:0]  out_out_byte,
  output logic [31:0] out_position_in_part,
  output logic [31:0] out_file_length,
  output logic [15:0] out_file_number,
  output logic        out_last_of_file,
  output logic [1:0]  out_status,
  output logic        out_package_done,
  output logic [31:0] out_bytes_consumed,
  output logic [31:0] out_package_total
);

  pdm_pkg::stage_t stage_r, stage_nxt;
  pdm_pkg::ctl_t   ctl_r, ctl_nxt;
  logic [4:0]   hc_r, hc_nxt;
  logic [15:0]  fl_r, fl_nxt, fn_r, fn_nxt;
  logic [31:0]  seen_r, seen_nxt, tot_r, tot_nxt, hs_r, hs_nxt, fs_r, fs_nxt;
  logic [31:0]  off_r, off_nxt;
  logic [127:0] exp_r, exp_nxt;
  logic         fin_r, fin_nxt, fail_r, fail_nxt;
  logic [1:0]   pcls_r, pcls_nxt;
  logic [7:0]   pbyte_r, pbyte_nxt;
  logic [31:0]  ppos_r, ppos_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [1:0]   ocls_r, ocls_nxt, osts_r, osts_nxt;
  logic [7:0]   obyte_r, obyte_nxt;
  logic [31:0]  opos_r, opos_nxt;
  logic [15:0]  ofn_r, ofn_nxt;
  logic         olast_r, olast_nxt;

  logic acc, slot_free, go_final, emit, match;
  logic [4:0] hc1;
  logic [3:0] dsel;
  logic [1:0] est;
  pdm_pkg::md5_cmd_t cmd;
  pdm_pkg::md5_sts_t md5_sts;

  pdm_md5_core u_md5 (.clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(md5_sts));

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (ctl_r != pdm_pkg::CT_READY) || md5_sts.busy || !slot_free;
  assign acc       = in_valid && !in_stall;
  assign match     = (md5_sts.digest == exp_r);

  always_comb begin
    ctl_nxt = ctl_r;
    case (ctl_r)
      pdm_pkg::CT_READY: if (go_final) ctl_nxt = pdm_pkg::CT_FINAL;
      pdm_pkg::CT_FINAL: if (!md5_sts.busy) ctl_nxt = pdm_pkg::CT_CHECK;
      pdm_pkg::CT_CHECK: if (!md5_sts.busy && slot_free) ctl_nxt = pdm_pkg::CT_READY;
      default: ctl_nxt = pdm_pkg::CT_READY;
    endcase
  end

  always_comb begin
    stage_nxt = stage_r; hc_nxt = hc_r; fl_nxt = fl_r; fn_nxt = fn_r;
    seen_nxt = seen_r; tot_nxt = tot_r; hs_nxt = hs_r; fs_nxt = fs_r;
    off_nxt = off_r; exp_nxt = exp_r; fin_nxt = fin_r; fail_nxt = fail_r;
    pcls_nxt = pcls_r; pbyte_nxt = pbyte_r; ppos_nxt = ppos_r;
    ocls_nxt = ocls_r; obyte_nxt = obyte_r; opos_nxt = opos_r; ofn_nxt = ofn_r;
    olast_nxt = olast_r; osts_nxt = osts_r;
    go_final = 1'b0; emit = 1'b0;
    cmd = '0;
    cmd.data = in_in_byte;
    hc1 = 5'd0; dsel = 4'd0; est = pdm_pkg::STS_MATCH;
    if (acc) begin
      if (in_begin_package) begin
        stage_nxt = pdm_pkg::PS_PACKAGE; hc_nxt = 5'd0; fl_nxt = 16'd0; fn_nxt = 16'd0;
        seen_nxt = 32'd0; tot_nxt = 32'd0; hs_nxt = pdm_pkg::DEFAULT_HDR_SIZE;
        fs_nxt = 32'd0; exp_nxt = 128'd0; off_nxt = 32'd0; fin_nxt = 1'b0; fail_nxt = 1'b0;
        cmd.start = 1'b1;
      end
      if (!(fin_nxt || fail_nxt)) begin
        seen_nxt = seen_nxt + 32'd1;
        hc1 = hc_nxt + 5'd1;
        case (stage_nxt)
          pdm_pkg::PS_PACKAGE: begin
            if (hc_nxt < 5'd2) fl_nxt[{hc_nxt[0], 3'b000} +: 8] = in_in_byte;
            else if (hc_nxt >= 5'd4) tot_nxt[{hc_nxt[1:0], 3'b000} +: 8] = in_in_byte;
            hc_nxt = hc1;
            if (hc1 >= pdm_pkg::PKG_HDR_BYTES) begin
              hc_nxt = 5'd0;
              if (fl_nxt == 16'd0) begin
                fin_nxt = 1'b1;
                stage_nxt = pdm_pkg::PS_DONE;
              end else begin
                stage_nxt = pdm_pkg::PS_FILEHDR;
              end
            end
          end
          pdm_pkg::PS_FILEHDR: begin
            if (hc_nxt < 5'd4) begin
              if (hc_nxt == 5'd0) hs_nxt = 32'(in_in_byte);
              else hs_nxt[{hc_nxt[1:0], 3'b000} +: 8] = in_in_byte;
            end else if (hc_nxt < 5'd8) begin
              if (hc_nxt == 5'd4) fs_nxt = 32'(in_in_byte);
              else fs_nxt[{hc_nxt[1:0], 3'b000} +: 8] = in_in_byte;
            end else begin
              dsel = 4'(hc_nxt - 5'd8);
              exp_nxt[{dsel, 3'b000} +: 8] = in_in_byte;
            end
            hc_nxt = hc1;
            if (hc1 >= pdm_pkg::FILE_HDR_BYTES) begin
              hc_nxt = 5'd0;
              off_nxt = 32'd0;
              cmd.start = 1'b1;
              if (hs_nxt < 32'(pdm_pkg::FILE_HDR_BYTES)) begin
                fail_nxt = 1'b1;
                stage_nxt = pdm_pkg::PS_DONE;
                emit = 1'b1;
                ocls_nxt = pdm_pkg::CLS_EMPTY; obyte_nxt = 8'd0; opos_nxt = 32'd0;
                ofn_nxt = fn_nxt; olast_nxt = 1'b1; osts_nxt = pdm_pkg::STS_BAD_HDR;
              end else if (hs_nxt == 32'(pdm_pkg::FILE_HDR_BYTES)) begin
                stage_nxt = pdm_pkg::PS_DATA;
                if (fs_nxt == 32'd0) begin
                  go_final = 1'b1;
                  pcls_nxt = pdm_pkg::CLS_EMPTY; pbyte_nxt = 8'd0; ppos_nxt = 32'd0;
                end
              end else begin
                stage_nxt = pdm_pkg::PS_NAME;
              end
            end
          end
          pdm_pkg::PS_NAME: begin
            ppos_nxt = off_nxt;
            off_nxt = off_nxt + 32'd1;
            if (off_nxt == hs_nxt - 32'(pdm_pkg::FILE_HDR_BYTES)) begin
              off_nxt = 32'd0;
              stage_nxt = pdm_pkg::PS_DATA;
              if (fs_nxt == 32'd0) begin
                go_final = 1'b1;
                pcls_nxt = pdm_pkg::CLS_NAME; pbyte_nxt = in_in_byte;
              end
            end
            if (!go_final) begin
              emit = 1'b1;
              ocls_nxt = pdm_pkg::CLS_NAME; obyte_nxt = in_in_byte; opos_nxt = ppos_nxt;
              ofn_nxt = fn_nxt; olast_nxt = 1'b0; osts_nxt = pdm_pkg::STS_BUSY;
            end
          end
          pdm_pkg::PS_DATA: begin
            cmd.byte_en = 1'b1;
            ppos_nxt = off_nxt;
            off_nxt = off_nxt + 32'd1;
            if (off_nxt == fs_nxt) begin
              go_final = 1'b1;
              pcls_nxt = pdm_pkg::CLS_DATA; pbyte_nxt = in_in_byte;
            end else begin
              emit = 1'b1;
              ocls_nxt = pdm_pkg::CLS_DATA; obyte_nxt = in_in_byte; opos_nxt = ppos_nxt;
              ofn_nxt = fn_nxt; olast_nxt = 1'b0; osts_nxt = pdm_pkg::STS_BUSY;
            end
          end
          default: ;
        endcase
      end
    end else if (ctl_r == pdm_pkg::CT_FINAL) begin
      cmd.final_en = !md5_sts.busy;
    end else if (ctl_r == pdm_pkg::CT_CHECK && !md5_sts.busy && slot_free) begin
      // close the file: compare, count down, move on
      est = match ? pdm_pkg::STS_MATCH : pdm_pkg::STS_MISMATCH;
      fl_nxt = fl_r - 16'd1;
      fn_nxt = fn_r + 16'd1;
      if (fl_nxt == 16'd0) fin_nxt = 1'b1;
      if (!match) fail_nxt = 1'b1;
      hc_nxt = 5'd0;
      off_nxt = 32'd0;
      hs_nxt = pdm_pkg::DEFAULT_HDR_SIZE;
      stage_nxt = (fin_nxt || fail_nxt) ? pdm_pkg::PS_DONE : pdm_pkg::PS_FILEHDR;
      emit = 1'b1;
      ocls_nxt = pcls_r; obyte_nxt = pbyte_r; opos_nxt = ppos_r;
      ofn_nxt = fn_r; olast_nxt = 1'b1; osts_nxt = est;
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= pdm_pkg::PS_PACKAGE; ctl_r <= pdm_pkg::CT_READY;
      hc_r <= 5'd0; fl_r <= 16'd0; fn_r <= 16'd0; seen_r <= 32'd0; tot_r <= 32'd0;
      hs_r <= pdm_pkg::DEFAULT_HDR_SIZE; fs_r <= 32'd0; off_r <= 32'd0; exp_r <= 128'd0;
      fin_r <= 1'b0; fail_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      stage_r <= stage_nxt; ctl_r <= ctl_nxt;
      hc_r <= hc_nxt; fl_r <= fl_nxt; fn_r <= fn_nxt; seen_r <= seen_nxt; tot_r <= tot_nxt;
      hs_r <= hs_nxt; fs_r <= fs_nxt; off_r <= off_nxt; exp_r <= exp_nxt;
      fin_r <= fin_nxt; fail_r <= fail_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  // payload holds while stalled: only written on emit
  always_ff @(posedge clk) begin
    pcls_r <= pcls_nxt; pbyte_r <= pbyte_nxt; ppos_r <= ppos_nxt;
    if (emit) begin
      ocls_r <= ocls_nxt; obyte_r <= obyte_nxt; opos_r <= opos_nxt; ofn_r <= ofn_nxt;
      olast_r <= olast_nxt; osts_r <= osts_nxt;
    end
  end

  logic [31:0] ofs_r, oseen_r, otot_r;
  logic        odone_r;
  always_ff @(posedge clk) begin
    if (emit) begin
      ofs_r <= fs_nxt; oseen_r <= seen_nxt; otot_r <= tot_nxt; odone_r <= fin_nxt || fail_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_byte_class       = ocls_r;
  assign out_out_byte         = obyte_r;
  assign out_position_in_part = opos_r;
  assign out_file_length      = ofs_r;
  assign out_file_number      = ofn_r;
  assign out_last_of_file     = olast_r;
  assign out_status           = osts_r;
  assign out_package_done     = odone_r;
  assign out_bytes_consumed   = oseen_r;
  assign out_package_total    = otot_r;

  `PDM_ASSERT(a_check_emits, (ctl_r == pdm_pkg::CT_CHECK && !md5_sts.busy && slot_free) |=> (out_valid_r && out_last_of_file), "file end gave no result")
  `PDM_ASSERT(a_status_last, (out_valid_r && out_status != pdm_pkg::STS_BUSY) |-> out_last_of_file, "final status without end of file")
  `PDM_ASSERT(a_stall_busy, (ctl_r != pdm_pkg::CT_READY || md5_sts.busy) |-> in_stall, "input taken while hashing")

endmodule

// ===== rtl/core/pdm_md5_core.sv =====
// Iterative MD5 engine: one round per cycle over a buffered 64-byte block.
`include "package_deframer_md5_check_defines.svh"

module pdm_md5_core (
  input  logic              clk,
  input  logic              rst_n,
  input  pdm_pkg::md5_cmd_t cmd,
  output pdm_pkg::md5_sts_t sts
);

  pdm_pkg::md_state_t state_r, state_nxt;
  logic [127:0] chain_r;
  logic [63:0]  count_r;
  logic [511:0] block_r;
  logic [511:0] padded;
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [5:0]   rnd_r;
  logic         second_r;
  logic [5:0]   idx;
  logic [31:0]  f, m, t, rot, round_b;
  logic [3:0]   g, ii;
  logic [63:0]  wide;
  logic [127:0] sum;

  assign idx = count_r[8:3];
  assign sts.busy = (state_r != pdm_pkg::MD_IDLE);
  assign sts.digest = chain_r;

  // round function
  always_comb begin
    ii = rnd_r[3:0];
    case (rnd_r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = ii; end
      2'd1: begin f = (d_r & b_r) | (~d_r & c_r); g = 4'(ii * 4'd5 + 4'd1); end
      2'd2: begin f = b_r ^ c_r ^ d_r; g = 4'(ii * 4'd3 + 4'd5); end
      default: begin f = c_r ^ (b_r | ~d_r); g = 4'(ii * 4'd7); end
    endcase
    m = block_r[{g, 5'b00000} +: 32];
    t = a_r + f + pdm_pkg::md5_k(rnd_r) + m;
    wide = {t, t} << pdm_pkg::md5_rot({rnd_r[5:4], rnd_r[1:0]});
    rot = wide[63:32];
    round_b = b_r + rot;
    sum = {chain_r[127:96] + d_r, chain_r[95:64] + c_r, chain_r[63:32] + b_r,
           chain_r[31:0] + a_r};
  end

  // pad the current block: marker byte, zeros, and the length when it fits
  always_comb begin
    for (int j = 0; j < 64; j++) begin
      if (6'(j) == idx) padded[8*j +: 8] = 8'h80;
      else if (6'(j) > idx) padded[8*j +: 8] = 8'h00;
      else padded[8*j +: 8] = block_r[8*j +: 8];
    end
    if (idx <= 6'd55) padded[511:448] = count_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdm_pkg::MD_IDLE: begin
        if ((cmd.byte_en && idx == 6'd63) || cmd.final_en) state_nxt = pdm_pkg::MD_ROUND;
      end
      pdm_pkg::MD_ROUND: begin
        if (rnd_r == 6'd63) state_nxt = pdm_pkg::MD_ADD;
      end
      pdm_pkg::MD_ADD: begin
        state_nxt = second_r ? pdm_pkg::MD_ROUND : pdm_pkg::MD_IDLE;
      end
      default: state_nxt = pdm_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pdm_pkg::MD_IDLE;
      chain_r  <= pdm_pkg::MD5_IV;
      count_r  <= 64'd0;
      second_r <= 1'b0;
      rnd_r    <= 6'd0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        pdm_pkg::MD_IDLE: begin
          if (cmd.start) begin
            chain_r <= pdm_pkg::MD5_IV;
            count_r <= 64'd0;
          end else if (cmd.byte_en) begin
            block_r[{idx, 3'b000} +: 8] <= cmd.data;
            count_r <= count_r + 64'd8;
            {d_r, c_r, b_r, a_r} <= chain_r;
            rnd_r <= 6'd0;
          end else if (cmd.final_en) begin
            block_r  <= padded;
            second_r <= (idx > 6'd55);
            {d_r, c_r, b_r, a_r} <= chain_r;
            rnd_r <= 6'd0;
          end
        end
        pdm_pkg::MD_ROUND: begin
          a_r <= d_r;
          b_r <= round_b;
          c_r <= b_r;
          d_r <= c_r;
          rnd_r <= rnd_r + 6'd1;
        end
        pdm_pkg::MD_ADD: begin
          chain_r <= sum;
          {d_r, c_r, b_r, a_r} <= sum;
          rnd_r <= 6'd0;
          if (second_r) begin
            block_r  <= {count_r, 448'd0};
            second_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `PDM_ASSERT(a_round_end, (state_r == pdm_pkg::MD_ROUND && rnd_r == 6'd63) |=> (state_r == pdm_pkg::MD_ADD), "round 63 not followed by add")
  `PDM_ASSERT(a_byte_idle, cmd.byte_en |-> (state_r == pdm_pkg::MD_IDLE), "byte written while hashing")
  `PDM_ASSERT(a_final_idle, cmd.final_en |-> (state_r == pdm_pkg::MD_IDLE && !cmd.start), "final issued while busy")

endmodule

// ===== verif/tb_package_deframer_md5_check.sv =====
// Self-checking testbench for the package deframer with per-file MD5 check.
module tb_package_deframer_md5_check;

  typedef logic [7:0] blk_t [64];
  typedef logic [7:0] bytes_t [$];

  typedef struct {
    bit         bgn;
    logic [7:0] b;
    bit         hold;
  } pkt_byte_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [7:0]  data;
    logic [31:0] pos;
    logic [31:0] flen;
    logic [15:0] fnum;
    logic        last;
    logic [1:0]  status;
    logic        done;
    logic [31:0] consumed;
    logic [31:0] total;
  } frag_t;

  localparam int TARGET_BYTES = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int SHIFT_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_begin_package;
  logic [7:0]  in_in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_byte_class;
  logic [7:0]  out_out_byte;
  logic [31:0] out_position_in_part;
  logic [31:0] out_file_length;
  logic [15:0] out_file_number;
  logic        out_last_of_file;
  logic [1:0]  out_status;
  logic        out_package_done;
  logic [31:0] out_bytes_consumed;
  logic [31:0] out_package_total;

  package_deframer_md5_check u_dut (.*);

  pkt_byte_t stream_q [$];
  frag_t     frag_exp_q [$];
  int        mismatches;
  int        accepted;
  int        total_items;
  int        quiet_cycles;
  int        cycles;
  int        gen_bytes;

  // predictor state
  pdm_pkg::stage_t pr_stage;
  int unsigned  pr_hcnt;
  logic [15:0]  pr_left;
  logic [15:0]  pr_fnum;
  logic [31:0]  pr_seen;
  logic [31:0]  pr_total;
  logic [31:0]  pr_hsize;
  logic [31:0]  pr_fsize;
  logic [127:0] pr_xdig;
  logic [31:0]  pr_off;
  logic [127:0] pr_chain;
  blk_t         pr_blk;
  logic [63:0]  pr_bits;
  bit           pr_fin;
  bit           pr_fail;

  function automatic logic [127:0] md5_compress(logic [127:0] h, blk_t blk);
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, s;
    int g;
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = h[31:0]; b = h[63:32]; c = h[95:64]; d = h[127:96];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5*i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3*i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7*i) % 16;
      end
      t = d; d = c; c = b;
      s = a + f + SINE_K[i] + m[g];
      b = b + ((s << SHIFT_S[(i/16)*4 + i%4]) | (s >> (32 - SHIFT_S[(i/16)*4 + i%4])));
      a = t;
    end
    return {h[127:96] + d, h[95:64] + c, h[63:32] + b, h[31:0] + a};
  endfunction

  function automatic logic [127:0] md5_finish(logic [127:0] h, blk_t blk, logic [63:0] nbits);
    int idx;
    idx = int'(nbits[8:3]);
    blk[idx] = 8'h80;
    idx++;
    if (idx > 56) begin
      for (int i = idx; i < 64; i++) blk[i] = 8'h00;
      h = md5_compress(h, blk);
      idx = 0;
    end
    for (int i = idx; i < 56; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = nbits[8*i +: 8];
    return md5_compress(h, blk);
  endfunction

  function automatic logic [127:0] md5_of(bytes_t q);
    logic [127:0] h;
    blk_t         blk;
    logic [63:0]  nbits;
    h = pdm_pkg::MD5_IV;
    nbits = '0;
    foreach (blk[i]) blk[i] = 8'h00;
    foreach (q[i]) begin
      blk[nbits[8:3]] = q[i];
      nbits += 8;
      if (nbits[8:3] == 0) h = md5_compress(h, blk);
    end
    return md5_finish(h, blk, nbits);
  endfunction

  function automatic frag_t make_frag(logic [1:0] cls, logic [7:0] data, logic [31:0] pos,
                                      logic [15:0] fnum, logic last, logic [1:0] status);
    frag_t r;
    r.cls = cls; r.data = data; r.pos = pos; r.flen = pr_fsize; r.fnum = fnum;
    r.last = last; r.status = status; r.done = pr_fin | pr_fail;
    r.consumed = pr_seen; r.total = pr_total;
    return r;
  endfunction

  task automatic clear_parser();
    pr_stage = pdm_pkg::PS_PACKAGE; pr_hcnt = 0; pr_left = '0; pr_fnum = '0; pr_seen = '0;
    pr_total = '0; pr_hsize = pdm_pkg::DEFAULT_HDR_SIZE; pr_fsize = '0; pr_xdig = '0;
    pr_off = '0; pr_chain = pdm_pkg::MD5_IV; pr_bits = '0; pr_fin = 0; pr_fail = 0;
    foreach (pr_blk[i]) pr_blk[i] = 8'h00;
  endtask

  task automatic close_file(logic [1:0] cls, logic [7:0] data, logic [31:0] pos);
    logic [15:0] fnum;
    logic [1:0]  status;
    fnum = pr_fnum;
    status = (md5_finish(pr_chain, pr_blk, pr_bits) == pr_xdig) ?
             pdm_pkg::STS_MATCH : pdm_pkg::STS_MISMATCH;
    pr_left--;
    pr_fnum++;
    if (pr_left == 0) pr_fin = 1;
    if (status == pdm_pkg::STS_MISMATCH) pr_fail = 1;
    pr_hcnt = 0; pr_off = '0; pr_hsize = pdm_pkg::DEFAULT_HDR_SIZE;
    pr_stage = (pr_fin || pr_fail) ? pdm_pkg::PS_DONE : pdm_pkg::PS_FILEHDR;
    frag_exp_q.push_back(make_frag(cls, data, pos, fnum, 1'b1, status));
  endtask

  task automatic predict_byte(bit bgn, logic [7:0] b);
    int unsigned idx;
    logic [31:0] pos;
    if (bgn) clear_parser();
    if (pr_fin || pr_fail) return;
    pr_seen++;
    idx = pr_hcnt;
    case (pr_stage)
      pdm_pkg::PS_PACKAGE: begin
        if (idx < 2) pr_left[8*idx +: 8] = b;
        else if (idx >= 4 && idx < 8) pr_total[8*(idx-4) +: 8] = b;
        pr_hcnt = idx + 1;
        if (pr_hcnt >= pdm_pkg::PKG_HDR_BYTES) begin
          pr_hcnt = 0;
          if (pr_left == 0) begin
            pr_fin = 1; pr_stage = pdm_pkg::PS_DONE;
          end else pr_stage = pdm_pkg::PS_FILEHDR;
        end
      end
      pdm_pkg::PS_FILEHDR: begin
        if (idx < 4) begin
          if (idx == 0) pr_hsize = {24'h0, b}; else pr_hsize[8*idx +: 8] = b;
        end else if (idx < 8) begin
          if (idx == 4) pr_fsize = {24'h0, b}; else pr_fsize[8*(idx-4) +: 8] = b;
        end else pr_xdig[8*(idx-8) +: 8] = b;
        pr_hcnt = idx + 1;
        if (pr_hcnt >= pdm_pkg::FILE_HDR_BYTES) begin
          pr_hcnt = 0; pr_off = '0; pr_chain = pdm_pkg::MD5_IV; pr_bits = '0;
          if (pr_hsize < pdm_pkg::FILE_HDR_BYTES) begin
            pr_fail = 1; pr_stage = pdm_pkg::PS_DONE;
            frag_exp_q.push_back(make_frag(pdm_pkg::CLS_EMPTY, 8'h00, '0, pr_fnum, 1'b1,
                                           pdm_pkg::STS_BAD_HDR));
          end else if (pr_hsize == pdm_pkg::FILE_HDR_BYTES) begin
            pr_stage = pdm_pkg::PS_DATA;
            if (pr_fsize == 0) close_file(pdm_pkg::CLS_EMPTY, 8'h00, '0);
          end else pr_stage = pdm_pkg::PS_NAME;
        end
      end
      pdm_pkg::PS_NAME: begin
        pos = pr_off;
        pr_off++;
        if (pr_off == pr_hsize - pdm_pkg::FILE_HDR_BYTES) begin
          pr_off = '0;
          pr_stage = pdm_pkg::PS_DATA;
          if (pr_fsize == 0) begin
            close_file(pdm_pkg::CLS_NAME, b, pos);
            return;
          end
        end
        frag_exp_q.push_back(make_frag(pdm_pkg::CLS_NAME, b, pos, pr_fnum, 1'b0,
                                       pdm_pkg::STS_BUSY));
      end
      pdm_pkg::PS_DATA: begin
        pos = pr_off;
        pr_blk[pr_bits[8:3]] = b;
        pr_bits += 8;
        if (pr_bits[8:3] == 0) pr_chain = md5_compress(pr_chain, pr_blk);
        pr_off++;
        if (pr_off == pr_fsize) close_file(pdm_pkg::CLS_DATA, b, pos);
        else frag_exp_q.push_back(make_frag(pdm_pkg::CLS_DATA, b, pos, pr_fnum, 1'b0,
                                            pdm_pkg::STS_BUSY));
      end
      default: ;
    endcase
  endtask

  // stimulus building
  task automatic put(bit bgn, logic [7:0] b, bit hold = 0);
    pkt_byte_t p;
    p.bgn = bgn; p.b = b; p.hold = hold;
    stream_q.push_back(p);
    gen_bytes++;
  endtask

  task automatic put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) put(0, v[8*i +: 8]);
  endtask

  task automatic put_pkg_header(logic [15:0] count, logic [31:0] total, bit hold = 0);
    logic [15:0] ver;
    ver = 16'($urandom);
    put(1, count[7:0], hold);
    put(0, count[15:8]);
    put(0, ver[7:0]);
    put(0, ver[15:8]);
    put32(total);
  endtask

  // kind: 0 good digest, 1 wrong digest, 2 header size below 24
  task automatic put_file(int name_len, int size, int kind, logic [7:0] fill = 8'h00,
                          bit fixed = 0);
    bytes_t       body;
    logic [127:0] dig;
    logic [31:0]  hsize;
    for (int i = 0; i < size; i++) body.push_back(fixed ? fill : 8'($urandom));
    dig = md5_of(body);
    if (kind == 1) dig[$urandom_range(127, 0)] ^= 1'b1;
    hsize = (kind == 2) ? $urandom_range(pdm_pkg::FILE_HDR_BYTES - 1, 0) :
                          pdm_pkg::FILE_HDR_BYTES + name_len;
    put32(hsize);
    put32(size);
    for (int i = 0; i < 16; i++) put(0, dig[8*i +: 8]);
    if (kind == 2) return;
    for (int i = 0; i < name_len; i++) put(0, 8'($urandom));
    foreach (body[i]) put(0, body[i]);
  endtask

  task automatic put_random_package(bit hold);
    int nf, kind, sz, roll;
    nf = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(4, 1);
    put_pkg_header(16'(nf), $urandom, hold);
    for (int f = 0; f < nf; f++) begin
      roll = $urandom_range(99, 0);
      kind = (roll < 8) ? 1 : (roll < 13) ? 2 : 0;
      sz = ($urandom_range(9, 0) == 0) ? $urandom_range(140, 55) : $urandom_range(20, 0);
      // cut the package short now and then; the next begin restarts parsing
      if ($urandom_range(19, 0) == 0) begin
        for (int i = $urandom_range(30, 1); i > 0; i--) put(0, 8'($urandom));
        return;
      end
      put_file(($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1), sz, kind);
      if (kind != 0) break;
    end
    for (int i = $urandom_range(3, 0); i > 0; i--) put(0, 8'($urandom));
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    bit hold_done;
    rst_n = 0;
    in_valid = 0;
    in_begin_package = 0;
    in_in_byte = '0;
    out_stall = 0;
    mismatches = 0;
    accepted = 0;
    gen_bytes = 0;
    hold_done = 0;
    clear_parser();

    // zero file count, then ignored bytes
    put_pkg_header(16'h0000, 32'hffff_ffff);
    put(0, 8'hff);
    put(0, 8'h00);
    // empty file without name, empty file with name, extreme data bytes, full block
    put_pkg_header(16'd5, 32'h0000_0000);
    put_file(0, 0, 0);
    put_file(2, 0, 0);
    put_file(1, 1, 0, 8'hff, 1);
    put_file(0, 2, 0, 8'h00, 1);
    put_file(0, 64, 0);
    // wrong digest stops the package
    put_pkg_header(16'd2, 32'h1234_5678);
    put_file(1, 3, 1);
    put(0, 8'h5a);
    // header size below 24
    put_pkg_header(16'd1, 32'h0);
    put_file(0, 4, 2);
    // long tail that needs an extra padding block
    put_pkg_header(16'hffff, 32'h0);
    put_file(0, 57, 0);

    while (gen_bytes < TARGET_BYTES) begin
      put_random_package(!hold_done && gen_bytes > TARGET_BYTES / 2);
      if (gen_bytes > TARGET_BYTES / 2) hold_done = 1;
    end
    total_items = stream_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1;

    wait (stream_q.size() == 0 && !in_valid);
    wait (frag_exp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && frag_exp_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int phase_pct(bit sender);
    int ph;
    ph = (total_items == 0) ? 0 : (accepted * 4) / total_items;
    case (ph)
      0: return 0;
      1: return sender ? 56 : 0;
      2: return sender ? 0 : 56;
      default: return 21;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    bit take;
    if (rst_n) begin
      take = in_valid && !in_stall;
      if (take) begin
        predict_byte(in_begin_package, in_in_byte);
        accepted++;
        void'(stream_q.pop_front());
      end
      quiet_cycles = (frag_exp_q.size() == 0) ? quiet_cycles + 1 : 0;
      if (in_valid && !take) begin
        // hold the stalled transaction
      end else if (stream_q.size() != 0 &&
                   !(stream_q[0].hold && quiet_cycles < DRAIN_CYCLES) &&
                   $urandom_range(99, 0) >= phase_pct(1)) begin
        in_valid <= 1;
        in_begin_package <= stream_q[0].bgn;
        in_in_byte <= stream_q[0].b;
      end else begin
        in_valid <= 0;
      end
      out_stall <= ($urandom_range(99, 0) < phase_pct(0));
    end else begin
      quiet_cycles = 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    frag_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte_class, out_out_byte, out_position_in_part, out_file_length,
              out_file_number, out_last_of_file, out_status, out_package_done,
              out_bytes_consumed, out_package_total};
      if (frag_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", got);
      end else begin
        want = frag_exp_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
